// ===== sv/eslc_pkg.sv =====
`default_nettype none
package eslc_pkg;
    localparam int LAYERS = 64;
    localparam int EXPERTS = 256;
    localparam int SLOTS = 64;
    localparam int LW = 6;
    localparam int XW = 8;
    localparam int SW = 6;
    localparam int CW = 48;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    localparam logic [2:0] CMD_FIND = 3'd0;
    localparam logic [2:0] CMD_HOLD = 3'd1;
    localparam logic [2:0] CMD_ADMIT = 3'd2;
    localparam logic [2:0] CMD_STEP = 3'd3;
    localparam logic [2:0] CMD_READ = 3'd4;

    localparam logic [2:0] CNT_LOOKUP = 3'd0;
    localparam logic [2:0] CNT_HIT = 3'd1;
    localparam logic [2:0] CNT_ADMIT = 3'd2;
    localparam logic [2:0] CNT_EVICT = 3'd3;
    localparam logic [2:0] CNT_STARVE = 3'd4;
    localparam logic [2:0] CNT_STEPS = 3'd5;
    localparam int N_CNT = 6;

    localparam logic [1:0] REG_EXPERTS = 2'd0;
    localparam logic [1:0] REG_SLOTS   = 2'd1;
    localparam logic [1:0] REG_FIXED   = 2'd2;

    // slot-side entry: valid, expert, last used, held
    typedef struct packed {
        logic valid;
        logic [XW-1:0] expert;
        logic [63:0] last_used;
        logic [63:0] held;
    } slot_ent_t;

    // expert-side entry
    typedef struct packed {
        logic valid;
        logic [SW-1:0] slot;
    } map_ent_t;
endpackage
`default_nettype wire

// ===== sv/eslc_ram.sv =====
`default_nettype none
module eslc_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/expert_slot_lru_cache_unit.sv =====
`default_nettype none
// Expert-to-slot LRU cache with one table per layer, held in two synchronous
// RAMs (expert map, slot table), each with one read and one write port. After
// reset or any register write, a clearing pass over all LAYERS*EXPERTS = 16384
// map words initializes both RAMs; no word is accepted then. An admit that
// misses scans the ring slots (slots_in_use - fixed_slots) of its layer one per
// cycle through the slot RAM read port. One word is in work at a time; an
// output register holds the finished result so the next word can enter while it
// waits, and a result not yet taken stalls the end of the next.
module expert_slot_lru_cache_unit import eslc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], layer[8:3], expert[16:9], counter_index[19:17], zero pad
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // slot[6:0], evicted_expert[15:7], counter_value[63:16]
    output logic [63:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);
    typedef enum logic [3:0] {
        CLEAR, IDLE, RD_MAP, WT_MAP, RD_SLOT, WT_SLOT, SCAN, SCAN_END,
        RD_VIC, WT_VIC, WR_VIC, DONE
    } state_t;

    state_t state_reg;
    logic [8:0] eiu_reg;
    logic [6:0] siu_reg, fix_reg;
    logic [8:0] eff_e;
    logic [6:0] eff_s, eff_f;
    logic [63:0] tick_reg;
    logic [CW-1:0] cnt_reg [N_CNT];
    logic [LW+XW-1:0] clr_reg;
    logic [2:0] cmd_reg, ci_reg;
    logic [LW-1:0] lay_reg;
    logic [XW-1:0] x_reg;
    logic [6:0] scan_reg;
    logic [SW-1:0] vic_reg;
    logic vic_ok_reg, vic_free_reg;
    logic [63:0] vic_lu_reg;
    logic out_pend_reg;
    logic [63:0] out_data_reg;
    logic [6:0] res_slot_reg;
    logic [8:0] res_ev_reg;
    logic [CW-1:0] res_cv_reg;
    map_ent_t map_ent_reg;

    // effective sizes
    always_comb begin
        logic [8:0] cap;
        eff_e = (eiu_reg == 9'd0) ? 9'd1 : eiu_reg;
        cap = (eff_e < 9'(SLOTS)) ? eff_e : 9'(SLOTS);
        eff_s = (siu_reg == 7'd0) ? 7'd1 : ((9'(siu_reg) > cap) ? cap[6:0] : siu_reg);
        eff_f = (fix_reg > eff_s) ? eff_s : fix_reg;
    end

    // map RAM
    logic m_we;
    logic [LW+XW-1:0] m_wa, m_ra;
    map_ent_t m_wd, m_rd;
    eslc_ram #(.AW(LW+XW), .DW($bits(map_ent_t))) u_map (
        .aclk(aclk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

    // slot RAM
    logic t_we;
    logic [LW+SW-1:0] t_wa, t_ra;
    slot_ent_t t_wd, t_rd;
    eslc_ram #(.AW(LW+SW), .DW($bits(slot_ent_t))) u_slot (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

    logic ok;
    assign ok = 9'(x_reg) < eff_e;
    assign s_tready = (state_reg == IDLE) && !cfg_we;
    assign m_tvalid = out_pend_reg;
    assign m_tdata = out_data_reg;

    logic [SW-1:0] scan_s;
    assign scan_s = scan_reg[SW-1:0];
    logic [XW-1:0] clr_x;
    assign clr_x = clr_reg[XW-1:0];
    logic [SW-1:0] hold_s;
    assign hold_s = map_ent_reg.slot;
    logic finish;
    assign finish = (state_reg == DONE) && (!out_pend_reg || m_tready);

    always_comb begin
        m_we = 1'b0; m_wa = clr_reg; m_wd = '0;
        t_we = 1'b0; t_wa = {clr_reg[LW+XW-1:XW], clr_x[SW-1:0]}; t_wd = '0;
        m_ra = {lay_reg, x_reg};
        t_ra = {lay_reg, (state_reg == SCAN) ? scan_s : hold_s};
        if (state_reg == RD_VIC || state_reg == WT_VIC) t_ra = {lay_reg, vic_reg};
        case (state_reg)
            CLEAR: begin
                m_we = 1'b1;
                m_wd.valid = 9'(clr_x) < 9'(eff_f);
                m_wd.slot = clr_x[SW-1:0];
                t_we = 9'(clr_x) < 9'(SLOTS);
                t_wd.valid = 9'(clr_x) < 9'(eff_f);
                t_wd.expert = clr_x;
                t_wd.last_used = {63'd0, t_wd.valid};
            end
            WT_SLOT: begin
                // hold or resident admit: refresh ticks
                t_we = 1'b1; t_wa = {lay_reg, hold_s};
                t_wd = t_rd; t_wd.last_used = tick_reg; t_wd.held = tick_reg;
            end
            WR_VIC: begin
                t_we = 1'b1; t_wa = {lay_reg, vic_reg};
                t_wd.valid = 1'b1; t_wd.expert = x_reg;
                t_wd.last_used = tick_reg; t_wd.held = tick_reg;
                m_we = 1'b1; m_wa = {lay_reg, x_reg};
                m_wd.valid = 1'b1; m_wd.slot = vic_reg;
            end
            WT_VIC: begin
                // invalidate old owner's map entry
                m_we = t_rd.valid; m_wa = {lay_reg, t_rd.expert}; m_wd = '0;
            end
            default: ;
        endcase
    end

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + CW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR; clr_reg <= '0; out_pend_reg <= 1'b0;
            eiu_reg <= 9'd256; siu_reg <= 7'd64; fix_reg <= 7'd0;
            tick_reg <= 64'd1;
            for (int i = 0; i < N_CNT; i++) cnt_reg[i] <= '0;
        end else begin
            if (finish && !cfg_we) out_pend_reg <= 1'b1;
            else if (out_pend_reg && m_tready) out_pend_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_EXPERTS: eiu_reg <= cfg_data;
                    REG_SLOTS: siu_reg <= cfg_data[6:0];
                    REG_FIXED: fix_reg <= cfg_data[6:0];
                    default: ;
                endcase
                if (cfg_index inside {REG_EXPERTS, REG_SLOTS, REG_FIXED}) begin
                    state_reg <= CLEAR; clr_reg <= '0; tick_reg <= 64'd1;
                    for (int i = 0; i < N_CNT; i++) cnt_reg[i] <= '0;
                end
            end else begin
                case (state_reg)
                    CLEAR: begin
                        clr_reg <= clr_reg + 1'b1;
                        if (&clr_reg) state_reg <= IDLE;
                    end
                    IDLE: if (s_tvalid) begin
                        cmd_reg <= s_tdata[2:0]; lay_reg <= s_tdata[8:3];
                        x_reg <= s_tdata[16:9]; ci_reg <= s_tdata[19:17];
                        res_slot_reg <= '1; res_ev_reg <= '1; res_cv_reg <= '0;
                        state_reg <= RD_MAP;
                    end
                    RD_MAP: begin
                        case (cmd_reg)
                            CMD_FIND, CMD_HOLD, CMD_ADMIT: state_reg <= ok ? WT_MAP : DONE;
                            CMD_STEP: begin
                                tick_reg <= tick_reg + 64'd1;
                                cnt_reg[CNT_STEPS] <= sat(cnt_reg[CNT_STEPS]);
                                state_reg <= DONE;
                            end
                            CMD_READ: begin
                                if (ci_reg < 3'(N_CNT)) res_cv_reg <= cnt_reg[ci_reg];
                                state_reg <= DONE;
                            end
                            default: state_reg <= DONE;
                        endcase
                    end
                    WT_MAP: begin
                        map_ent_reg <= m_rd;
                        if (cmd_reg == CMD_FIND) begin
                            if (m_rd.valid) res_slot_reg <= {1'b0, m_rd.slot};
                            state_reg <= DONE;
                        end else if (m_rd.valid) begin
                            cnt_reg[CNT_LOOKUP] <= sat(cnt_reg[CNT_LOOKUP]);
                            cnt_reg[CNT_HIT] <= sat(cnt_reg[CNT_HIT]);
                            res_slot_reg <= {1'b0, m_rd.slot};
                            state_reg <= RD_SLOT;
                        end else if (cmd_reg == CMD_HOLD) begin
                            cnt_reg[CNT_LOOKUP] <= sat(cnt_reg[CNT_LOOKUP]);
                            state_reg <= DONE;
                        end else begin
                            scan_reg <= eff_f; vic_ok_reg <= 1'b0; vic_free_reg <= 1'b0;
                            state_reg <= (eff_f < eff_s) ? SCAN : SCAN_END;
                        end
                    end
                    RD_SLOT: state_reg <= WT_SLOT;
                    WT_SLOT: state_reg <= DONE;
                    SCAN: begin
                        // read issued for scan_s; result next cycle in SCAN/SCAN_END
                        scan_reg <= scan_reg + 7'd1;
                        if (scan_reg + 7'd1 >= eff_s) state_reg <= SCAN_END;
                        if (scan_reg != eff_f) begin
                            if (!vic_free_reg) begin
                                if (!t_rd.valid) begin
                                    vic_free_reg <= 1'b1; vic_ok_reg <= 1'b1;
                                    vic_reg <= SW'(scan_reg - 7'd1);
                                end else if (t_rd.held != tick_reg &&
                                        (!vic_ok_reg || t_rd.last_used < vic_lu_reg)) begin
                                    vic_ok_reg <= 1'b1; vic_reg <= SW'(scan_reg - 7'd1);
                                    vic_lu_reg <= t_rd.last_used;
                                end
                            end
                        end
                    end
                    SCAN_END: begin
                        logic got;
                        got = vic_ok_reg;
                        if (eff_f < eff_s && !vic_free_reg) begin
                            if (!t_rd.valid) begin
                                got = 1'b1; vic_reg <= SW'(scan_reg - 7'd1);
                            end else if (t_rd.held != tick_reg &&
                                    (!vic_ok_reg || t_rd.last_used < vic_lu_reg)) begin
                                got = 1'b1; vic_reg <= SW'(scan_reg - 7'd1);
                            end
                        end
                        if (got) state_reg <= RD_VIC;
                        else begin
                            cnt_reg[CNT_STARVE] <= sat(cnt_reg[CNT_STARVE]);
                            state_reg <= DONE;
                        end
                    end
                    RD_VIC: state_reg <= WT_VIC;
                    WT_VIC: begin
                        if (t_rd.valid) begin
                            res_ev_reg <= {1'b0, t_rd.expert};
                            cnt_reg[CNT_EVICT] <= sat(cnt_reg[CNT_EVICT]);
                        end
                        state_reg <= WR_VIC;
                    end
                    WR_VIC: begin
                        res_slot_reg <= {1'b0, vic_reg};
                        cnt_reg[CNT_ADMIT] <= sat(cnt_reg[CNT_ADMIT]);
                        state_reg <= DONE;
                    end
                    DONE: if (finish) begin
                        out_data_reg <= {res_cv_reg, res_ev_reg, res_slot_reg};
                        state_reg <= IDLE;
                    end
                    default: state_reg <= IDLE;
                endcase
            end
        end
    end

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == CLEAR |-> !s_tready) else $error("accept during clear");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        finish && !cfg_we |=> m_tvalid) else $error("result lost");
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SCAN |-> scan_reg < eff_s) else $error("scan out of range");
endmodule
`default_nettype wire
